// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and control structures shared by the block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Map storage is organized as words of usage bits.
	localparam int WORD_W = 32;
	localparam int BIT_W  = $clog2(WORD_W);

	// Payload widths fixed by the interface.
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int COUNT_MAX = 511;

	// Parameter defaults.
	localparam int NUM_BLOCKS_DEF     = 256;
	localparam int RESERVED_START_DEF = 0;
	localparam int RESERVED_COUNT_DEF = 1;

	// Operation codes carried on the kind field.
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOCATE = 2'd0,
		KIND_REQUEST  = 2'd1,
		KIND_RELEASE  = 2'd2
	} kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input beat
		logic ptr_clr;   // reset the word pointer
		logic init_wr;   // write the reset word at the pointer, advance
		logic rd_scan;   // read the word at the pointer, advance
		logic rd_named;  // read the word holding the named block
		logic commit;    // update map and count, load the result
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_alloc;  // captured operation is allocate
		logic named_ok;  // request or release of a block inside the map
		logic ptr_end;   // pointer has passed the last word
		logic data_ok;   // read data register holds a fresh word
		logic hit;       // that word has a free block
		logic last;      // that word is the last word of the map
	} dp_status_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller for the block allocator: sequences the reset sweep, the word
// scan of an allocate, the single read of a request or release, and the
// commit into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bba_pkg::dp_status_t status,
	output bba_pkg::ctl_cmd_t   cmd
);
	import bba_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or draining.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_next;
		end
	end

	// Output valid flag: set by a commit, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_INIT: begin
				if (status.ptr_end) begin
					state_next = ST_IDLE;
				end else begin
					cmd.init_wr = 1'b1;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.ptr_clr = 1'b1;
					state_next  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.is_alloc) begin
					state_next = ST_SCAN;
				end else begin
					cmd.rd_named = status.named_ok;
					state_next   = ST_COMMIT;
				end
			end
			ST_SCAN: begin
				// Stop on the first word with a free block, or after the last word.
				if (status.data_ok && (status.hit || status.last)) begin
					state_next = ST_COMMIT;
				end else begin
					cmd.rd_scan = !status.ptr_end;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_INIT;
			end
		endcase
	end

	// A commit never overwrites a result that is still waiting.
	`BBA_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.commit, !out_valid_q || out_ready)
	// A commit always presents a result in the next cycle.
	`BBA_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q)
	// Neither the reset sweep nor the scan advances past the end of the map.
	`BBA_ASSERT_IMPLY(a_scan_bound, clk, arst_n, cmd.rd_scan || cmd.init_wr, !status.ptr_end)

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Datapath of the block allocator: usage-map RAM, word pointer, first-free
// search over one word, used-block counter and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath #(
	parameter int NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
	parameter int RESERVED_START = bba_pkg::RESERVED_START_DEF,
	parameter int RESERVED_COUNT = bba_pkg::RESERVED_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::ctl_cmd_t             cmd,
	output bba_pkg::dp_status_t           status,
	input  logic [bba_pkg::KIND_W-1:0]    kind,
	input  logic [bba_pkg::INDEX_W-1:0]   block_index,
	output logic                          success,
	output logic [bba_pkg::INDEX_W-1:0]   granted_index,
	output logic [bba_pkg::COUNT_W-1:0]   used_count,
	output logic [bba_pkg::COUNT_W-1:0]   free_count
);
	import bba_pkg::*;

	localparam int DEPTH      = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int RES_END    = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
		(RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
	localparam int RESET_USED = (RES_END > RESERVED_START) ? (RES_END - RESERVED_START) : 0;

	logic [KIND_W-1:0]  kind_q;
	logic [INDEX_W-1:0] idx_q;
	logic [ADDR_W:0]    ptr_q;
	logic [ADDR_W-1:0]  addr_s1;
	logic               rd_valid_s1;
	logic [CNT_W-1:0]   used_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [WORD_W-1:0]  wr_data;

	logic               named_ok;
	logic [ADDR_W-1:0]  idx_word;
	logic [WORD_W-1:0]  idx_onehot;
	logic [WORD_W-1:0]  free_vec;
	logic [WORD_W-1:0]  low_onehot;
	logic [BIT_W-1:0]   low_pos;
	logic               hit;

	logic               chg_en;
	logic [WORD_W-1:0]  chg_word;
	logic               res_ok;
	logic [INDEX_W-1:0] res_index;
	logic [CNT_W-1:0]   used_next;
	logic [CNT_W-1:0]   free_next;

	// Reset contents of one map word: the reserved run, clipped to the map.
	function automatic logic [WORD_W-1:0] init_word(input logic [ADDR_W:0] a);
		logic [WORD_W-1:0] w;
		int                b;
		w = '0;
		for (int i = 0; i < WORD_W; i++) begin
			b    = (int'(a) << BIT_W) + i;
			w[i] = (b >= RESERVED_START) && (b < RES_END);
		end
		return w;
	endfunction

	// Bits of a word that stand for real blocks.
	function automatic logic [WORD_W-1:0] word_mask(input logic [ADDR_W-1:0] a);
		logic [WORD_W-1:0] w;
		for (int i = 0; i < WORD_W; i++) begin
			w[i] = ((int'(a) << BIT_W) + i) < NUM_BLOCKS;
		end
		return w;
	endfunction

	// Saturate a count to the output field.
	function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
		return (32'(v) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(v);
	endfunction

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			idx_q  <= block_index;
		end
	end

	// Word pointer for the reset sweep and the allocate scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.rd_scan || cmd.init_wr) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// Read tracking: which word the read data register holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
	end

	// Named block decode.
	assign named_ok   = ((kind_q == KIND_REQUEST) || (kind_q == KIND_RELEASE)) &&
		(32'(idx_q) < NUM_BLOCKS);
	assign idx_word   = ADDR_W'(idx_q >> BIT_W);
	assign idx_onehot = WORD_W'(1) << idx_q[BIT_W-1:0];

	// Map RAM ports.
	assign rd_en   = cmd.rd_scan || cmd.rd_named;
	assign rd_addr = cmd.rd_named ? idx_word : ptr_q[ADDR_W-1:0];
	assign wr_en   = cmd.init_wr || (cmd.commit && chg_en);
	assign wr_addr = cmd.init_wr ? ptr_q[ADDR_W-1:0] : addr_s1;
	assign wr_data = cmd.init_wr ? init_word(ptr_q) : chg_word;

	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Lowest free block in the word: isolate the lowest set bit, then encode.
	assign free_vec   = ~rd_data & word_mask(addr_s1);
	assign low_onehot = free_vec & (~free_vec + 1'b1);
	assign hit        = |free_vec;

	always_comb begin
		low_pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low_onehot[i]) begin
				low_pos = low_pos | BIT_W'(i);
			end
		end
	end

	// Outcome of the operation held in the capture registers.
	always_comb begin
		chg_en    = 1'b0;
		chg_word  = rd_data;
		res_ok    = 1'b0;
		res_index = '0;
		used_next = used_q;
		case (kind_q)
			KIND_ALLOCATE: begin
				if (hit) begin
					chg_en    = 1'b1;
					chg_word  = rd_data | low_onehot;
					res_ok    = 1'b1;
					res_index = INDEX_W'({addr_s1, low_pos});
					used_next = used_q + 1'b1;
				end
			end
			KIND_REQUEST: begin
				if (named_ok && ((rd_data & idx_onehot) == '0)) begin
					chg_en    = 1'b1;
					chg_word  = rd_data | idx_onehot;
					res_ok    = 1'b1;
					res_index = idx_q;
					used_next = used_q + 1'b1;
				end
			end
			KIND_RELEASE: begin
				if (named_ok) begin
					res_ok = 1'b1;
					if ((rd_data & idx_onehot) != '0) begin
						chg_en    = 1'b1;
						chg_word  = rd_data & ~idx_onehot;
						used_next = used_q - 1'b1;
					end
				end
			end
			default: begin
				chg_en = 1'b0;
			end
		endcase
	end

	assign free_next = CNT_W'(NUM_BLOCKS) - used_next;

	// Used-block counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= CNT_W'(RESET_USED);
		end else if (cmd.commit) begin
			used_q <= used_next;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success       <= res_ok;
			granted_index <= res_index;
			used_count    <= sat_count(used_next);
			free_count    <= sat_count(free_next);
		end
	end

	// Status to the controller.
	assign status.is_alloc = (kind_q == KIND_ALLOCATE);
	assign status.named_ok = named_ok;
	assign status.ptr_end  = (32'(ptr_q) == DEPTH);
	assign status.data_ok  = rd_valid_s1;
	assign status.hit      = hit;
	assign status.last     = (32'(addr_s1) == DEPTH - 1);

	// The used count never exceeds the map size.
	`BBA_ASSERT_IMPLY(a_used_bound, clk, arst_n, 1'b1, 32'(used_q) <= NUM_BLOCKS)
	// A release never raises the used count.
	`BBA_ASSERT_NEXT(a_release_dec, clk, arst_n, cmd.commit && (kind_q == KIND_RELEASE), used_q <= $past(used_q))

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bitmap block allocator: allocate the lowest free block, claim a
// named block, or release one, reporting used and free block counts.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_ready    kind, block_index
//   out      source     out_valid / out_ready  success, granted_index,
//                                              used_count, free_count
//
// After reset a sweep writes the reserved run into the map RAM, one 32-bit
// word per cycle; in_ready stays low until the sweep has passed the last word.
// Request, release and unused kinds pass DISPATCH, which reads the word of a
// named block inside the map, and COMMIT; allocate passes DISPATCH, then SCAN,
// which reads map words in order on the single read port of the map RAM up to
// the first word with a free block (the last word when the map is full), then
// COMMIT. One item is in work at a time; the next beat can be taken in the cycle
// after the commit, even with a result still in the output register; a commit waits until that result is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
	parameter int RESERVED_START = bba_pkg::RESERVED_START_DEF,
	parameter int RESERVED_COUNT = bba_pkg::RESERVED_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bba_pkg::KIND_W-1:0]    kind,
	input  logic [bba_pkg::INDEX_W-1:0]   block_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          success,
	output logic [bba_pkg::INDEX_W-1:0]   granted_index,
	output logic [bba_pkg::COUNT_W-1:0]   used_count,
	output logic [bba_pkg::COUNT_W-1:0]   free_count
);
	import bba_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Sequencing.
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Map, search and counters.
	bba_datapath #(
		.NUM_BLOCKS     (NUM_BLOCKS),
		.RESERVED_START (RESERVED_START),
		.RESERVED_COUNT (RESERVED_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.block_index   (block_index),
		.success       (success),
		.granted_index (granted_index),
		.used_count    (used_count),
		.free_count    (free_count)
	);

endmodule

// ===== sim/tb_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Self-checking bench for the first-fit bitmap block allocator. A short
// directed table covers reset state, reserved blocks, repeated request and
// release, unused kinds and lowest-block reuse. Random phases then fill the
// map to full, churn, drain and swap blocks. Each result beat is checked field
// by field against its fixed table row or a local predictor of map and count.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int BLOCKS       = NUM_BLOCKS_DEF;
	localparam int RSV_START    = RESERVED_START_DEF;
	localparam int RSV_COUNT    = RESERVED_COUNT_DEF;
	localparam int RANDOM_OPS   = 1250;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_LIMIT  = 50;

	// The fourth kind code has no operation behind it.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef enum int {
		PH_FILL,
		PH_CHURN,
		PH_DRAIN,
		PH_SWAP
	} phase_t;

	typedef struct packed {
		logic                success;
		logic [INDEX_W-1:0]  granted_index;
		logic [COUNT_W-1:0]  used_count;
		logic [COUNT_W-1:0]  free_count;
	} grant_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [INDEX_W-1:0]  index;
		logic                fixed;
		grant_t              want;
	} op_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   op_kind = '0;
	logic [INDEX_W-1:0]  op_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                success;
	logic [INDEX_W-1:0]  granted_index;
	logic [COUNT_W-1:0]  used_count;
	logic [COUNT_W-1:0]  free_count;

	// Predicted allocator state.
	logic [BLOCKS-1:0]   usage_map;
	int unsigned         used_total;

	grant_t              expected_grants[$];
	op_row_t             directed_ops[$];
	int                  error_count = 0;
	int                  sent = 0;
	int                  idle_cycles = 0;
	bit                  quiet = 1'b0;

	bitmap_block_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (op_kind),
		.block_index   (op_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.success       (success),
		.granted_index (granted_index),
		.used_count    (used_count),
		.free_count    (free_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mismatch reporting: one line per error, printing capped, counting not.
	task automatic report_error(input string msg);
		if (error_count < PRINT_LIMIT) begin
			$display("ERROR %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_error($sformatf("%s got %0d, expected %0d", name, got, want));
		end
	endtask

	function automatic logic [COUNT_W-1:0] clamp_count(input int unsigned v);
		return (v > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : v[COUNT_W-1:0];
	endfunction

	// Reset state: only the part of the reserved run inside the map is set.
	function automatic void reset_usage_map();
		int b;
		usage_map = '0;
		used_total = 0;
		for (int i = 0; i < RSV_COUNT; i++) begin
			b = RSV_START + i;
			if (b < BLOCKS && !usage_map[b]) begin
				usage_map[b] = 1'b1;
				used_total++;
			end
		end
	endfunction

	// Apply one operation to the predicted map and return its result beat.
	function automatic grant_t apply_block_op(input logic [KIND_W-1:0] k,
			input logic [INDEX_W-1:0] idx);
		grant_t g;
		g = '0;
		case (k)
			KIND_ALLOCATE: begin
				for (int b = 0; b < BLOCKS; b++) begin
					if (!usage_map[b]) begin
						usage_map[b] = 1'b1;
						used_total++;
						g.success = 1'b1;
						g.granted_index = b[INDEX_W-1:0];
						break;
					end
				end
			end
			KIND_REQUEST: begin
				if (int'(idx) < BLOCKS && !usage_map[idx]) begin
					usage_map[idx] = 1'b1;
					used_total++;
					g.success = 1'b1;
					g.granted_index = idx;
				end
			end
			KIND_RELEASE: begin
				if (int'(idx) < BLOCKS) begin
					if (usage_map[idx]) begin
						usage_map[idx] = 1'b0;
						used_total--;
					end
					g.success = 1'b1;
				end
			end
			default: ;
		endcase
		g.used_count = clamp_count(used_total);
		g.free_count = clamp_count(BLOCKS - used_total);
		return g;
	endfunction

	// Pick a block in the wanted state, starting from a random point.
	function automatic logic [INDEX_W-1:0] pick_block(input logic want_used);
		int start;
		int b;
		start = $urandom_range(0, BLOCKS - 1);
		for (int n = 0; n < BLOCKS; n++) begin
			b = (start + n) % BLOCKS;
			if (usage_map[b] == want_used) begin
				return b[INDEX_W-1:0];
			end
		end
		return start[INDEX_W-1:0];
	endfunction

	function automatic op_row_t typed_row(input logic [KIND_W-1:0] k,
			input logic [INDEX_W-1:0] idx, input logic s, input int g,
			input int u, input int f);
		op_row_t r;
		r.kind = k;
		r.index = idx;
		r.fixed = 1'b1;
		r.want.success = s;
		r.want.granted_index = g[INDEX_W-1:0];
		r.want.used_count = u[COUNT_W-1:0];
		r.want.free_count = f[COUNT_W-1:0];
		return r;
	endfunction

	function automatic op_row_t checked_row(input logic [KIND_W-1:0] k,
			input logic [INDEX_W-1:0] idx);
		op_row_t r;
		r = '0;
		r.kind = k;
		r.index = idx;
		return r;
	endfunction

	// Drive one input beat after a random gap and log its expected result.
	// Valid stays high across back-to-back beats so it is never dropped and
	// raised in the same step.
	task automatic send_op(input logic [KIND_W-1:0] k,
			input logic [INDEX_W-1:0] idx, input logic fixed, input grant_t want);
		int gap;
		grant_t g;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op_kind <= k;
		op_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		g = apply_block_op(k, idx);
		expected_grants.push_back(fixed ? want : g);
		sent++;
	endtask

	task automatic send_random(input logic [KIND_W-1:0] k,
			input logic [INDEX_W-1:0] idx);
		send_op(k, idx, 1'b0, '0);
	endtask

	// Result sink: random stall before each beat, sometimes none at all.
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_grants.size() == 0) begin
				report_error("result beat with no expectation pending");
			end else begin
				want = expected_grants.pop_front();
				check_field("success", 32'(success), 32'(want.success));
				check_field("granted_index", 32'(granted_index),
					32'(want.granted_index));
				check_field("used_count", 32'(used_count), 32'(want.used_count));
				check_field("free_count", 32'(free_count), 32'(want.free_count));
			end
		end
	end

	// Watchdog on cycles without any beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL bitmap_block_allocator");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		phase_t mode;
		int r;
		bit first_phase;

		reset_usage_map();

		// Directed table. Block 0 is reserved, so one block is used at reset.
		directed_ops.push_back(typed_row(KIND_ALLOCATE, 8'd0,   1'b1, 1,   2, 254));
		directed_ops.push_back(typed_row(KIND_ALLOCATE, 8'd255, 1'b1, 2,   3, 253));
		directed_ops.push_back(typed_row(KIND_REQUEST,  8'd0,   1'b0, 0,   3, 253));
		directed_ops.push_back(typed_row(KIND_REQUEST,  8'd255, 1'b1, 255, 4, 252));
		directed_ops.push_back(typed_row(KIND_REQUEST,  8'd255, 1'b0, 0,   4, 252));
		directed_ops.push_back(typed_row(KIND_RELEASE,  8'd255, 1'b1, 0,   3, 253));
		directed_ops.push_back(typed_row(KIND_RELEASE,  8'd255, 1'b1, 0,   3, 253));
		directed_ops.push_back(typed_row(KIND_UNUSED,   8'hAA,  1'b0, 0,   3, 253));
		directed_ops.push_back(typed_row(KIND_UNUSED,   8'h55,  1'b0, 0,   3, 253));
		directed_ops.push_back(typed_row(KIND_RELEASE,  8'd1,   1'b1, 0,   2, 254));
		directed_ops.push_back(typed_row(KIND_ALLOCATE, 8'hFF,  1'b1, 1,   3, 253));
		directed_ops.push_back(typed_row(KIND_RELEASE,  8'd0,   1'b1, 0,   2, 254));
		directed_ops.push_back(typed_row(KIND_ALLOCATE, 8'h00,  1'b1, 0,   3, 253));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd128));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd127));
		directed_ops.push_back(checked_row(KIND_RELEASE,  8'd2));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd2));
		directed_ops.push_back(checked_row(KIND_RELEASE,  8'd128));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd31));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd32));
		directed_ops.push_back(checked_row(KIND_REQUEST,  8'd33));
		directed_ops.push_back(checked_row(KIND_ALLOCATE, 8'd7));
		directed_ops.push_back(checked_row(KIND_RELEASE,  8'd255));
		directed_ops.push_back(checked_row(KIND_UNUSED,   8'd255));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_ops[i]) begin
			send_op(directed_ops[i].kind, directed_ops[i].index,
				directed_ops[i].fixed, directed_ops[i].want);
		end

		// Random phases; the first one always fills the map to full.
		first_phase = 1'b1;
		while (sent < directed_ops.size() + RANDOM_OPS) begin
			mode = first_phase ? PH_FILL : phase_t'($urandom_range(0, 3));
			first_phase = 1'b0;
			quiet = ($urandom_range(0, 3) == 0);
			case (mode)
				// Allocate until full, then a few allocates on the full map.
				PH_FILL: begin
					while (used_total < BLOCKS) begin
						r = $urandom_range(0, 9);
						if (r == 0) begin
							send_random(KIND_REQUEST, pick_block(1'b0));
						end else if (r == 1) begin
							send_random(KIND_REQUEST, pick_block(1'b1));
						end else begin
							send_random(KIND_ALLOCATE, INDEX_W'($urandom_range(0, 255)));
						end
					end
					repeat ($urandom_range(1, 3)) begin
						send_random(KIND_ALLOCATE, INDEX_W'($urandom_range(0, 255)));
					end
				end
				// Mixed traffic with random indexes.
				PH_CHURN: begin
					repeat ($urandom_range(30, 60)) begin
						r = $urandom_range(0, 99);
						if (r < 35) begin
							send_random(KIND_ALLOCATE, INDEX_W'($urandom_range(0, 255)));
						end else if (r < 60) begin
							send_random(KIND_REQUEST, INDEX_W'($urandom_range(0, 255)));
						end else if (r < 70) begin
							send_random(KIND_REQUEST, pick_block(1'b1));
						end else if (r < 95) begin
							send_random(KIND_RELEASE, INDEX_W'($urandom_range(0, 255)));
						end else begin
							send_random(KIND_UNUSED, INDEX_W'($urandom_range(0, 255)));
						end
					end
				end
				// Mostly release used blocks, some releases of free ones and some allocates.
				PH_DRAIN: begin
					repeat ($urandom_range(40, 120)) begin
						r = $urandom_range(0, 99);
						if (r < 75) begin
							send_random(KIND_RELEASE, pick_block(1'b1));
						end else if (r < 90) begin
							send_random(KIND_RELEASE, pick_block(1'b0));
						end else begin
							send_random(KIND_ALLOCATE, INDEX_W'($urandom_range(0, 255)));
						end
					end
				end
				// Free a used block, then allocate: the lowest hole gets reused.
				default: begin
					repeat ($urandom_range(10, 25)) begin
						send_random(KIND_RELEASE, pick_block(1'b1));
						send_random(KIND_ALLOCATE, INDEX_W'($urandom_range(0, 255)));
					end
				end
			endcase
		end
		in_valid <= 1'b0;

		while (expected_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS bitmap_block_allocator");
		end else begin
			$display("FAIL bitmap_block_allocator");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_datapath.sv
hw/rtl/bitmap_block_allocator.sv
sim/tb_bitmap_block_allocator.sv
